FILE: sv/rzc_pkg.sv
// rzc_pkg: shared payload widths and types for the radial zigzag cube reorder.
// No dependencies; used by the channel interfaces and the top level.
package rzc_pkg;

   localparam int SAMPLE_W = 32;
   localparam int POS_W    = 9;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [POS_W-1:0]    pos_type;

endpackage

FILE: sv/rzc_if.sv
// rzc_if: valid/ready channel interfaces for sample input, result output and
// the direction register write port. Depends on rzc_pkg.

interface rzc_req_if;
   logic                valid;
   logic                ready;
   rzc_pkg::sample_type sample;
   logic                drain;

   modport source (output valid, output sample, output drain, input ready);
   modport sink   (input valid, input sample, input drain, output ready);
endinterface

interface rzc_rsp_if;
   logic                valid;
   logic                ready;
   rzc_pkg::sample_type sample_out;
   rzc_pkg::pos_type    out_position;
   logic                cube_end;

   modport source (output valid, output sample_out, output out_position,
                   output cube_end, input ready);
   modport sink   (input valid, input sample_out, input out_position,
                   input cube_end, output ready);
endinterface

interface rzc_csr_if;
   logic valid;
   logic ready;
   logic direction;

   modport source (output valid, output direction, input ready);
   modport sink   (input valid, input direction, output ready);
endinterface

FILE: sv/radial_zigzag_cube_reorder.sv
// Radial zigzag cube reorder: ping-pong cube buffer with a constant order ROM.
// Depends on rzc_pkg and the channel interfaces in rzc_if.sv.
// The order ROM read, then the bank read, are registered. Throughput: one word
// per cycle unless rsp stalls; set by one bank write and one bank read per cycle.
// Reset clears fill count, bank select, flush flag, direction and pipeline valids;
// the cube banks are not cleared and the order tables are constants.
module radial_zigzag_cube_reorder #(
   parameter int ELEM_WIDTH = 32,
   parameter int AXIS_BITS  = 3
) (
   input  logic          clock,
   input  logic          reset,
   rzc_req_if.sink       req,
   rzc_rsp_if.source     rsp,
   rzc_csr_if.sink       csr
);
   import rzc_pkg::*;

   localparam int IDX_W     = 3 * AXIS_BITS;
   localparam int CUBE_SIZE = 1 << IDX_W;
   localparam int AXIS_MASK = (1 << AXIS_BITS) - 1;
   localparam int MAX_DIST  = 3 * AXIS_MASK * AXIS_MASK;
   localparam logic [IDX_W-1:0] LAST_POS = {IDX_W{1'b1}};

   typedef logic [IDX_W-1:0] tab_type [CUBE_SIZE];

   function automatic int sq_dist(input int i);
      int x, y, z;
      x = i & AXIS_MASK;
      y = (i >> AXIS_BITS) & AXIS_MASK;
      z = (i >> (2 * AXIS_BITS)) & AXIS_MASK;
      return x * x + y * y + z * z;
   endfunction

   // stable counting sort by squared distance, ties in raster order
   function automatic tab_type build_tab(input bit want_rank);
      tab_type order_t;
      tab_type rank_t;
      int      start [MAX_DIST+2];
      int      sum;
      int      c;
      int      r;
      sum = 0;
      for (int d = 0; d < MAX_DIST + 2; d++) start[d] = 0;
      for (int i = 0; i < CUBE_SIZE; i++) start[sq_dist(i)]++;
      for (int d = 0; d < MAX_DIST + 2; d++) begin
         c        = start[d];
         start[d] = sum;
         sum      = sum + c;
      end
      for (int i = 0; i < CUBE_SIZE; i++) begin
         r = start[sq_dist(i)];
         start[sq_dist(i)]++;
         order_t[r] = IDX_W'(i);
         rank_t[i]  = IDX_W'(r);
      end
      return want_rank ? rank_t : order_t;
   endfunction

   localparam tab_type ORDER_TAB = build_tab(1'b0);
   localparam tab_type RANK_TAB  = build_tab(1'b1);

   // control and state registers
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic             wb_ff, wb_in;
   logic             full_ff, full_in;
   logic             dir_ff;

   // stage 1: source index from the order ROM
   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_src_ff;
   logic [IDX_W-1:0] s1_pos_ff;
   logic             s1_rb_ff;

   // stage 2: bank read data, doubles as the output register
   logic                  rsp_valid_ff;
   logic [ELEM_WIDTH-1:0] rd_ff;
   logic [IDX_W-1:0]      rsp_pos_ff;

   logic [ELEM_WIDTH-1:0] bank_mem [2*CUBE_SIZE];

   logic                       adv;
   logic                       accept;
   logic                       active;
   logic                       emit;
   logic [ELEM_WIDTH+SAMPLE_W-1:0] wdata_ext;
   logic [ELEM_WIDTH+SAMPLE_W-1:0] rdata_ext;
   logic [IDX_W+POS_W-1:0]     pos_ext;

   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;
   assign accept    = req.valid && adv;
   // a drain word with nothing to flush leaves everything alone
   assign active    = accept && !(req.drain && !full_ff);
   assign emit      = active && full_ff;
   assign csr.ready = 1'b1;

   always_comb begin
      fill_in = fill_ff;
      wb_in   = wb_ff;
      full_in = full_ff;
      if (active) begin
         if (fill_ff == LAST_POS) begin
            fill_in = '0;
            wb_in   = !wb_ff;
            full_in = !req.drain;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         wb_ff        <= 1'b0;
         full_ff      <= 1'b0;
         dir_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         wb_ff   <= wb_in;
         full_ff <= full_in;
         if (csr.valid) begin
            dir_ff <= csr.direction;
         end
         if (adv) begin
            s1_valid_ff  <= emit;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // order ROM read, registered
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_src_ff <= dir_ff ? RANK_TAB[fill_ff] : ORDER_TAB[fill_ff];
         s1_pos_ff <= fill_ff;
         s1_rb_ff  <= !wb_ff;
      end
   end

   assign wdata_ext = {{ELEM_WIDTH{1'b0}}, req.sample};

   // bank write port
   always_ff @(posedge clock) begin
      if (active && !req.drain) begin
         bank_mem[{wb_ff, fill_ff}] <= wdata_ext[ELEM_WIDTH-1:0];
      end
   end

   // bank read port, the other bank is never written while it drains
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff      <= bank_mem[{s1_rb_ff, s1_src_ff}];
         rsp_pos_ff <= s1_pos_ff;
      end
   end

   assign rdata_ext        = {{SAMPLE_W{1'b0}}, rd_ff};
   assign pos_ext          = {{POS_W{1'b0}}, rsp_pos_ff};
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample_out   = rdata_ext[SAMPLE_W-1:0];
   assign rsp.out_position = pos_ext[POS_W-1:0];
   assign rsp.cube_end     = (rsp_pos_ff == LAST_POS);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// testbench: drives sample and drain words through the radial zigzag cube reorder and
// checks every result word against a cube buffer predictor kept in this file.
// Depends on rzc_pkg, the channel interfaces in rzc_if.sv and radial_zigzag_cube_reorder.
module testbench;
   import rzc_pkg::*;

   localparam int CUBE_WORDS    = 512;
   localparam int LAST_POS      = CUBE_WORDS - 1;
   localparam int MAX_SQ        = 147;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int NUM_RANDOM    = 800;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_GAP       = 18;

   typedef enum logic {
      DIR_GATHER  = 1'b0,
      DIR_SCATTER = 1'b1
   } dir_type;

   typedef struct packed {
      sample_type sample;
      pos_type    position;
      logic       cube_end;
   } word_type;

   typedef struct packed {
      sample_type sample;
      logic       drain;
      bit         no_word;
   } stim_type;

   logic clock = 1'b0;
   logic reset;

   rzc_req_if req_ch ();
   rzc_rsp_if rsp_ch ();
   rzc_csr_if csr_ch ();

   radial_zigzag_cube_reorder i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #5 clock = ~clock;

   // predictor state
   sample_type bank_data   [2][CUBE_WORDS];
   bit         bank_filled [2][CUBE_WORDS];
   pos_type    zigzag_to_raster [CUBE_WORDS];
   pos_type    raster_to_zigzag [CUBE_WORDS];
   pos_type    fill_pos  = '0;
   bit         wr_bank   = 1'b0;
   bit         flushing  = 1'b0;
   dir_type    dir_now   = DIR_GATHER;

   word_type pending_words [$];
   int       mismatches     = 0;
   int       cycles         = 0;
   bit       calm_sender    = 1'b0;
   bit       calm_receiver  = 1'b0;

   // directed opening: nothing can come out before the first cube is full
   stim_type boot_rows [20] = '{
      '{32'hFFFF_FFFF, 1'b1, 1'b1},
      '{32'h0000_0000, 1'b1, 1'b1},
      '{32'h0000_0000, 1'b0, 1'b1},
      '{32'hFFFF_FFFF, 1'b0, 1'b1},
      '{32'h0000_0001, 1'b0, 1'b1},
      '{32'h8000_0000, 1'b0, 1'b1},
      '{32'h7FFF_FFFF, 1'b0, 1'b1},
      '{32'hAAAA_AAAA, 1'b0, 1'b1},
      '{32'h5555_5555, 1'b0, 1'b1},
      '{32'h1234_5678, 1'b1, 1'b1},
      '{32'hFFFF_0000, 1'b0, 1'b1},
      '{32'h0000_FFFF, 1'b0, 1'b1},
      '{32'h00FF_00FF, 1'b0, 1'b1},
      '{32'hFF00_FF00, 1'b0, 1'b1},
      '{32'h0F0F_0F0F, 1'b0, 1'b1},
      '{32'hF0F0_F0F0, 1'b0, 1'b1},
      '{32'hDEAD_BEEF, 1'b0, 1'b1},
      '{32'h0000_0002, 1'b0, 1'b1},
      '{32'h4000_0000, 1'b0, 1'b1},
      '{32'h0000_0000, 1'b1, 1'b1}
   };

   // radial order: stable counting sort on x*x+y*y+z*z
   initial begin : radial_order
      int      dist_of   [CUBE_WORDS];
      int      next_rank [MAX_SQ+1];
      int      total;
      int      cnt;
      pos_type idx;
      total = 0;
      foreach (next_rank[d]) next_rank[d] = 0;
      for (int i = 0; i < CUBE_WORDS; i++) begin
         idx = pos_type'(i);
         dist_of[i] = idx[2:0] * idx[2:0] + idx[5:3] * idx[5:3] + idx[8:6] * idx[8:6];
         next_rank[dist_of[i]]++;
      end
      for (int d = 0; d <= MAX_SQ; d++) begin
         cnt = next_rank[d];
         next_rank[d] = total;
         total += cnt;
      end
      for (int i = 0; i < CUBE_WORDS; i++) begin
         zigzag_to_raster[next_rank[dist_of[i]]] = pos_type'(i);
         raster_to_zigzag[i] = pos_type'(next_rank[dist_of[i]]);
         next_rank[dist_of[i]]++;
      end
   end

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t ns: mismatch: %s", $time, msg);
   endfunction

   task automatic predict_reorder(input sample_type s, input logic drain,
                                  output bit ignored, output bit produced,
                                  output word_type w);
      pos_type src;
      ignored  = drain && !flushing;
      produced = 1'b0;
      w        = '0;
      if (!ignored) begin
         if (flushing) begin
            src = (dir_now == DIR_SCATTER) ? raster_to_zigzag[fill_pos]
                                           : zigzag_to_raster[fill_pos];
            w.sample   = bank_data[!wr_bank][src];
            w.position = fill_pos;
            w.cube_end = (fill_pos == LAST_POS);
            produced   = 1'b1;
         end
         if (!drain) begin
            bank_data[wr_bank][fill_pos]   = s;
            bank_filled[wr_bank][fill_pos] = 1'b1;
         end
         if (fill_pos == LAST_POS) begin
            wr_bank  = !wr_bank;
            flushing = !drain;
         end
         fill_pos = fill_pos + 1'b1;
      end
   endtask

   task automatic send_word(input sample_type s, input logic drain, input bit no_word,
                            output bit ignored);
      int       gap;
      bit       produced;
      word_type w;
      gap = calm_sender ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      req_ch.drain  <= drain;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      predict_reorder(s, drain, ignored, produced, w);
      if (produced && !no_word)
         pending_words.push_back(w);
   endtask

   // hold off until every predicted word is out, then let the pipeline empty
   task automatic settle(input int extra);
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_direction(input dir_type d);
      settle(SETTLE_CYCLES);
      csr_ch.valid     <= 1'b1;
      csr_ch.direction <= d;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      dir_now = d;
   endtask

   initial begin : stimulus
      bit         ignored;
      logic       drain;
      int         counted;
      int         phase;
      int         phase_len;
      dir_type    d;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.sample    <= '0;
      req_ch.drain     <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.direction <= DIR_GATHER;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_direction(DIR_SCATTER);
      write_direction(DIR_GATHER);
      foreach (boot_rows[i])
         send_word(boot_rows[i].sample, boot_rows[i].drain, boot_rows[i].no_word, ignored);

      counted = 0;
      phase   = 0;
      while (counted < NUM_RANDOM) begin
         if (phase == 0)
            d = DIR_GATHER;
         else if (phase == 1)
            d = DIR_SCATTER;
         else
            d = dir_type'($urandom_range(0, 1));
         write_direction(d);
         phase_len = $urandom_range(60, 260);
         for (int k = 0; k < phase_len && counted < NUM_RANDOM; k++) begin
            if ($urandom_range(0, 29) == 0)
               calm_sender = !calm_sender;
            // a drain mid flush leaves a stale entry, so only over a written one or the last one
            drain = 1'b0;
            if (flushing) begin
               if (fill_pos == LAST_POS)
                  drain = ($urandom_range(0, 2) == 0);
               else if (bank_filled[wr_bank][fill_pos])
                  drain = ($urandom_range(0, 11) == 0);
            end else begin
               drain = ($urandom_range(0, 19) == 0);
            end
            send_word($urandom, drain, 1'b0, ignored);
            if (!ignored)
               counted++;
         end
         phase++;
      end

      settle(TAIL_CYCLES);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin : result_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            calm_receiver = !calm_receiver;
         stall = calm_receiver ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   always @(posedge clock) begin : result_check
      word_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_words.size() == 0) begin
            flag_error($sformatf("unexpected word sample %h pos %0d end %b",
                                 rsp_ch.sample_out, rsp_ch.out_position, rsp_ch.cube_end));
         end else begin
            want = pending_words.pop_front();
            if (rsp_ch.sample_out !== want.sample ||
                rsp_ch.out_position !== want.position ||
                rsp_ch.cube_end !== want.cube_end)
               flag_error($sformatf("expected sample %h pos %0d end %b, got %h pos %0d end %b",
                                    want.sample, want.position, want.cube_end,
                                    rsp_ch.sample_out, rsp_ch.out_position,
                                    rsp_ch.cube_end));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

endmodule
